[design/redundant_rule_removal_unit_assert.svh]
// assertion macros for the redundant rule removal unit
`ifndef REDUNDANT_RULE_REMOVAL_UNIT_ASSERT_SVH
`define REDUNDANT_RULE_REMOVAL_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RRR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define RRR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/rrr_pkg.sv]
// types and helper functions of the redundant rule removal unit
package rrr_pkg;

	// one input transaction
	typedef struct packed {
		logic [31:0] src_ip_low;
		logic [31:0] src_ip_high;
		logic [31:0] dst_ip_low;
		logic [31:0] dst_ip_high;
		logic [15:0] src_port_low;
		logic [15:0] src_port_high;
		logic [15:0] dst_port_low;
		logic [15:0] dst_port_high;
		logic        final_rule;
	} rule_item_t;

	// one output transaction
	typedef struct packed {
		logic [31:0] out_src_ip_low;
		logic [31:0] out_src_ip_high;
		logic [31:0] out_dst_ip_low;
		logic [31:0] out_dst_ip_high;
		logic [15:0] out_src_port_low;
		logic [15:0] out_src_port_high;
		logic [15:0] out_dst_port_low;
		logic [15:0] out_dst_port_high;
		logic [5:0]  original_position;
		logic        rules_dropped;
		logic        end_of_run;
	} result_item_t;

	// the eight bounds of a rule as kept in memory
	typedef struct packed {
		logic [31:0] src_ip_low;
		logic [31:0] src_ip_high;
		logic [31:0] dst_ip_low;
		logic [31:0] dst_ip_high;
		logic [15:0] src_port_low;
		logic [15:0] src_port_high;
		logic [15:0] dst_port_low;
		logic [15:0] dst_port_high;
	} rule_bounds_t;

	// memory word: bounds plus the covered mark
	typedef struct packed {
		logic         covered;
		rule_bounds_t bounds;
	} rule_entry_t;

	// strip the control bit off an input transaction
	function automatic rule_bounds_t to_bounds(rule_item_t it);
		rule_bounds_t b;
		b.src_ip_low    = it.src_ip_low;
		b.src_ip_high   = it.src_ip_high;
		b.dst_ip_low    = it.dst_ip_low;
		b.dst_ip_high   = it.dst_ip_high;
		b.src_port_low  = it.src_port_low;
		b.src_port_high = it.src_port_high;
		b.dst_port_low  = it.dst_port_low;
		b.dst_port_high = it.dst_port_high;
		return b;
	endfunction

	// true when rule a contains rule b in all four ranges
	function automatic logic contains(rule_bounds_t a, rule_bounds_t b);
		return (a.src_ip_low <= b.src_ip_low) && (a.src_ip_high >= b.src_ip_high) &&
			(a.dst_ip_low <= b.dst_ip_low) && (a.dst_ip_high >= b.dst_ip_high) &&
			(a.src_port_low <= b.src_port_low) && (a.src_port_high >= b.src_port_high) &&
			(a.dst_port_low <= b.dst_port_low) && (a.dst_port_high >= b.dst_port_high);
	endfunction

endpackage

[design/rrr_rule_mem.sv]
// rule memory: one write port, one read port with registered read data
module rrr_rule_mem #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_addr,
	input  rrr_pkg::rule_entry_t wr_data,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     rd_addr,
	output rrr_pkg::rule_entry_t rd_data
);

	rrr_pkg::rule_entry_t mem [DEPTH];
	rrr_pkg::rule_entry_t rd_data_q;

	// storage array, read data held until the next read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/redundant_rule_removal_unit.sv]
// top level of the redundant rule removal unit
//
//   channel  | direction | handshake          | payload
//   rule     | in        | rule_valid/stall   | rrr_pkg::rule_item_t
//   result   | out       | result_valid/stall | rrr_pkg::result_item_t
//
// A stored rule is checked with one read per earlier rule on the registered read port,
// then written; the scan stops at the first cover.
// A rule arriving at full capacity is dropped without a scan. A final rule then walks every
// stored rule on the single read port, a read state and a check state each, held by output stalls.
// Reset clears the count, overflow flag and control; memory holds no reset.
// Output stalls only hold the emit loop; a waiting result does not block input.
`include "redundant_rule_removal_unit_assert.svh"

module redundant_rule_removal_unit #(
	parameter int MAX_RULES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rule_valid,
	output logic                  rule_stall,
	input  rrr_pkg::rule_item_t   rule,
	output logic                  result_valid,
	input  logic                  result_stall,
	output rrr_pkg::result_item_t result
);

	localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CNT_W = $clog2(MAX_RULES + 1);

	typedef enum logic [3:0] {
		ST_IDLE     = 4'b0001,
		ST_SCAN     = 4'b0010,
		ST_EMIT_RD  = 4'b0100,
		ST_EMIT_CHK = 4'b1000
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic                  overflow_q;
	logic [IDX_W-1:0]      last_live_q;
	rrr_pkg::rule_bounds_t rule_q;
	logic                  final_q;
	logic [CNT_W-1:0]      sidx_q;
	logic                  cov_q;
	logic                  rd_pend_s1;
	logic [IDX_W-1:0]      eidx_q;
	logic                  result_valid_q;
	rrr_pkg::result_item_t result_q;

	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	rrr_pkg::rule_entry_t  mem_wdata;
	logic                  mem_re;
	logic [IDX_W-1:0]      mem_raddr;
	rrr_pkg::rule_entry_t  mem_rdata;

	logic                  rule_acc;
	logic                  has_room;
	logic                  hit;
	logic                  cov_now;
	logic                  scan_issue;
	logic                  scan_done;
	logic                  last_entry;
	logic                  out_free;
	logic                  emit_load;
	logic                  emit_adv;

	rrr_rule_mem #(
		.DEPTH (MAX_RULES),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// input handshake
	assign rule_stall = (state_q != ST_IDLE);
	assign rule_acc   = rule_valid && !rule_stall;
	assign has_room   = (count_q < CNT_W'(MAX_RULES));

	// containment scan over earlier rules, one read per cycle
	assign hit        = rd_pend_s1 && rrr_pkg::contains(mem_rdata.bounds, rule_q);
	assign cov_now    = cov_q || hit;
	assign scan_issue = (state_q == ST_SCAN) && !cov_now && (sidx_q < count_q);
	assign scan_done  = (state_q == ST_SCAN) && !rd_pend_s1 && (cov_q || (sidx_q == count_q));

	// emit loop controls
	assign last_entry = ((CNT_W + 1)'(eidx_q) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(count_q);
	assign out_free   = !result_valid_q || !result_stall;
	assign emit_load  = (state_q == ST_EMIT_CHK) && !mem_rdata.covered && out_free;
	assign emit_adv   = (state_q == ST_EMIT_CHK) && (mem_rdata.covered || out_free);

	// memory port muxing
	always_comb begin
		mem_we            = scan_done;
		mem_waddr         = count_q[IDX_W-1:0];
		mem_wdata.covered = cov_q;
		mem_wdata.bounds  = rule_q;
		mem_re            = scan_issue || (state_q == ST_EMIT_RD);
		mem_raddr         = (state_q == ST_EMIT_RD) ? eidx_q : sidx_q[IDX_W-1:0];
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			overflow_q  <= 1'b0;
			last_live_q <= '0;
			sidx_q      <= '0;
			cov_q       <= 1'b0;
			rd_pend_s1  <= 1'b0;
			eidx_q      <= '0;
			final_q     <= 1'b0;
		end else begin
			rd_pend_s1 <= scan_issue;
			case (state_q)
				ST_IDLE: begin
					if (rule_acc) begin
						final_q <= rule.final_rule;
						sidx_q  <= '0;
						cov_q   <= 1'b0;
						eidx_q  <= '0;
						if (has_room) begin
							state_q <= ST_SCAN;
						end else begin
							overflow_q <= 1'b1;
							state_q    <= rule.final_rule ? ST_EMIT_RD : ST_IDLE;
						end
					end
				end
				ST_SCAN: begin
					cov_q <= cov_now;
					if (scan_issue) begin
						sidx_q <= sidx_q + CNT_W'(1);
					end
					if (scan_done) begin
						count_q <= count_q + CNT_W'(1);
						if (!cov_q) begin
							last_live_q <= count_q[IDX_W-1:0];
						end
						state_q <= final_q ? ST_EMIT_RD : ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_CHK;
				end
				ST_EMIT_CHK: begin
					if (emit_adv) begin
						if (last_entry) begin
							count_q    <= '0;
							overflow_q <= 1'b0;
							state_q    <= ST_IDLE;
						end else begin
							eidx_q  <= eidx_q + IDX_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// incoming rule bounds
	always_ff @(posedge clk) begin
		if (rule_acc) begin
			rule_q <= rrr_pkg::to_bounds(rule);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit_load) begin
			result_q.out_src_ip_low    <= mem_rdata.bounds.src_ip_low;
			result_q.out_src_ip_high   <= mem_rdata.bounds.src_ip_high;
			result_q.out_dst_ip_low    <= mem_rdata.bounds.dst_ip_low;
			result_q.out_dst_ip_high   <= mem_rdata.bounds.dst_ip_high;
			result_q.out_src_port_low  <= mem_rdata.bounds.src_port_low;
			result_q.out_src_port_high <= mem_rdata.bounds.src_port_high;
			result_q.out_dst_port_low  <= mem_rdata.bounds.dst_port_low;
			result_q.out_dst_port_high <= mem_rdata.bounds.dst_port_high;
			result_q.original_position <= 6'(eidx_q);
			result_q.rules_dropped     <= overflow_q;
			result_q.end_of_run        <= (eidx_q == last_live_q);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// checks
	`RRR_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_RULES),
		"stored rule count above capacity")
	`RRR_ASSERT_NOW(a_write_room, mem_we, (state_q == ST_SCAN) && has_room,
		"rule write outside scan or at full capacity")
	`RRR_ASSERT_NOW(a_emit_nonempty, state_q == ST_EMIT_RD, count_q != '0,
		"emit loop started on an empty set")
	`RRR_ASSERT_NEXT(a_load_origin, emit_load, result_valid_q && (state_q != ST_SCAN),
		"result load did not reach the output register")

endmodule

[tb/sv/tb_redundant_rule_removal_unit.sv]
// testbench for the redundant rule removal unit: directed table, random rule sets, scoreboard
`timescale 1ns / 100ps

module tb_redundant_rule_removal_unit;

	localparam int          CAPACITY     = 64;
	localparam int          RANDOM_RULES = 165;
	localparam int          DRAIN_CYCLES = 2 * CAPACITY + 20;
	localparam logic [31:0] IP_MAX       = 32'hFFFF_FFFF;
	localparam logic [15:0] PORT_MAX     = 16'hFFFF;

	// handshake idling pattern, rotated once per rule set
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// one row of the directed table; want is used only when typed is set
	typedef struct {
		rrr_pkg::rule_item_t   item;
		bit                    typed;
		rrr_pkg::result_item_t want;
	} table_row_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  rule_valid   = 1'b0;
	logic                  rule_stall;
	rrr_pkg::rule_item_t   rule         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	rrr_pkg::result_item_t result;

	idle_mode_t            idle_mode = IDLE_NONE;
	table_row_t            directed_rows[$];
	rrr_pkg::rule_bounds_t set_history[$];
	rrr_pkg::result_item_t pending_survivors[$];
	rrr_pkg::result_item_t survivors[$];

	// shadow copy of the rule set
	rrr_pkg::rule_bounds_t kept_rules[CAPACITY];
	bit                    kept_covered[CAPACITY];
	int                    kept_count    = 0;
	bit                    kept_overflow = 1'b0;

	int mismatch_count  = 0;
	int rules_sent      = 0;
	int sets_sent       = 0;
	int overflow_sets   = 0;
	int results_checked = 0;

	redundant_rule_removal_unit #(
		.MAX_RULES(CAPACITY)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.rule_valid  (rule_valid),
		.rule_stall  (rule_stall),
		.rule        (rule),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// rule a covers rule b in every range
	function automatic bit encloses(rrr_pkg::rule_bounds_t a, rrr_pkg::rule_bounds_t b);
		return !(a.src_ip_low > b.src_ip_low || a.src_ip_high < b.src_ip_high ||
			a.dst_ip_low > b.dst_ip_low || a.dst_ip_high < b.dst_ip_high ||
			a.src_port_low > b.src_port_low || a.src_port_high < b.src_port_high ||
			a.dst_port_low > b.dst_port_low || a.dst_port_high < b.dst_port_high);
	endfunction

	// store or drop one rule; on the last rule of a set fill survivors and clear
	function automatic void screen_rule(rrr_pkg::rule_item_t it);
		rrr_pkg::rule_bounds_t b;
		bit                    last_rule;
		bit                    covered;
		rrr_pkg::result_item_t r;
		{b, last_rule} = it;
		survivors.delete();
		if (kept_count < CAPACITY) begin
			covered = 1'b0;
			for (int i = 0; i < kept_count; i++)
				if (encloses(kept_rules[i], b))
					covered = 1'b1;
			kept_rules[kept_count]   = b;
			kept_covered[kept_count] = covered;
			kept_count++;
		end else begin
			kept_overflow = 1'b1;
		end
		if (last_rule) begin
			for (int i = 0; i < kept_count; i++)
				if (!kept_covered[i]) begin
					r = {kept_rules[i], 6'(i), kept_overflow, 1'b0};
					survivors.insert(survivors.size(), r);
				end
			if (survivors.size() > 0) begin
				r = survivors[survivors.size() - 1];
				r.end_of_run = 1'b1;
				survivors[survivors.size() - 1] = r;
			end
			kept_count    = 0;
			kept_overflow = 1'b0;
		end
	endfunction

	function automatic rrr_pkg::rule_item_t mk_rule(logic [31:0] sl, logic [31:0] sh,
			logic [31:0] dl, logic [31:0] dh, logic [15:0] spl, logic [15:0] sph,
			logic [15:0] dpl, logic [15:0] dph, bit last_rule);
		return {sl, sh, dl, dh, spl, sph, dpl, dph, last_rule};
	endfunction

	function automatic rrr_pkg::result_item_t mk_result(rrr_pkg::rule_item_t it, int pos,
			bit dropped, bit eor);
		return {rrr_pkg::to_bounds(it), 6'(pos), dropped, eor};
	endfunction

	function automatic void add_row(rrr_pkg::rule_item_t it, bit typed = 1'b0,
			rrr_pkg::result_item_t want = '0);
		table_row_t row;
		row = '{it, typed, want};
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	// bound value biased toward the edges
	function automatic logic [31:0] pick_bound(bit wide);
		logic [31:0] v;
		case ($urandom_range(5, 0))
			0:       v = '0;
			1:       v = '1;
			2:       v = $urandom_range(15, 0);
			3:       v = $urandom_range(1000, 0);
			default: v = $urandom;
		endcase
		if (!wide)
			v[31:16] = '0;
		return v;
	endfunction

	// fresh range for dimension d; mostly ordered, some left inverted
	function automatic void draw_range(int d, output logic [31:0] lo, output logic [31:0] hi);
		logic [31:0] a;
		logic [31:0] z;
		a = pick_bound(d < 2);
		z = pick_bound(d < 2);
		if (a > z && $urandom_range(3, 0) != 0) begin
			lo = z;
			hi = a;
		end else begin
			lo = a;
			hi = z;
		end
	endfunction

	function automatic rrr_pkg::rule_bounds_t join_bounds(logic [31:0] lo[4],
			logic [31:0] hi[4]);
		return {lo[0], hi[0], lo[1], hi[1], lo[2][15:0], hi[2][15:0], lo[3][15:0], hi[3][15:0]};
	endfunction

	// next rule of a random set: fresh, or a copy, narrowing or partial variant of an earlier one
	function automatic rrr_pkg::rule_bounds_t next_rule_bounds();
		logic [31:0]           lo[4];
		logic [31:0]           hi[4];
		logic [31:0]           t;
		rrr_pkg::rule_bounds_t base;
		int                    kind;
		int                    d;
		kind = (set_history.size() == 0) ? 0 : $urandom_range(3, 0);
		if (kind == 0) begin
			for (int k = 0; k < 4; k++)
				draw_range(k, lo[k], hi[k]);
		end else begin
			base  = set_history[$urandom_range(set_history.size() - 1, 0)];
			lo[0] = base.src_ip_low;
			hi[0] = base.src_ip_high;
			lo[1] = base.dst_ip_low;
			hi[1] = base.dst_ip_high;
			lo[2] = 32'(base.src_port_low);
			hi[2] = 32'(base.src_port_high);
			lo[3] = 32'(base.dst_port_low);
			hi[3] = 32'(base.dst_port_high);
			// shrink each ordered range inside itself
			if (kind >= 2) begin
				for (int k = 0; k < 4; k++) begin
					if (lo[k] <= hi[k]) begin
						t     = lo[k] + $urandom_range(hi[k] - lo[k], 0);
						hi[k] = t + $urandom_range(hi[k] - t, 0);
						lo[k] = t;
					end
				end
			end
			// redraw one range so the rule may escape in a single dimension
			if (kind == 3) begin
				d = $urandom_range(3, 0);
				draw_range(d, lo[d], hi[d]);
			end
		end
		return join_bounds(lo, hi);
	endfunction

	function automatic bit idle_roll(bit sender_side);
		int pct;
		case (idle_mode)
			IDLE_SENDER:   pct = sender_side ? 82 : 0;
			IDLE_RECEIVER: pct = sender_side ? 0 : 82;
			IDLE_BOTH:     pct = 11;
			default:       pct = 0;
		endcase
		return $urandom_range(99, 0) < pct;
	endfunction

	function automatic void note_mismatch(string msg);
		if (mismatch_count < 10)
			$display("ERROR at %0t ns: %s", $time, msg);
		mismatch_count++;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v)
			note_mismatch($sformatf("%s expected %h, got %h", name, want_v, got_v));
	endfunction

	// drive one rule transaction and record what it should produce
	task automatic send_rule(rrr_pkg::rule_item_t it, bit typed, rrr_pkg::result_item_t want);
		@(negedge clk);
		while (idle_roll(1'b1)) begin
			rule_valid <= 1'b0;
			@(negedge clk);
		end
		rule_valid <= 1'b1;
		rule       <= it;
		@(posedge clk);
		while (rule_stall)
			@(posedge clk);
		screen_rule(it);
		if (typed)
			pending_survivors.insert(pending_survivors.size(), want);
		else
			foreach (survivors[i])
				pending_survivors.insert(pending_survivors.size(), survivors[i]);
		rules_sent++;
		if (it.final_rule) begin
			sets_sent++;
			idle_mode = idle_mode_t'(sets_sent % 4);
		end
	endtask

	// receiver back-pressure
	always @(negedge clk)
		result_stall <= idle_roll(1'b0);

	// scoreboard on accepted result transactions
	always @(posedge clk) begin : check_results
		rrr_pkg::result_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_survivors.size() == 0) begin
				note_mismatch($sformatf("unexpected result for position %0d",
					result.original_position));
			end else begin
				want = pending_survivors.pop_front();
				compare_field("src_ip_low", want.out_src_ip_low, result.out_src_ip_low);
				compare_field("src_ip_high", want.out_src_ip_high, result.out_src_ip_high);
				compare_field("dst_ip_low", want.out_dst_ip_low, result.out_dst_ip_low);
				compare_field("dst_ip_high", want.out_dst_ip_high, result.out_dst_ip_high);
				compare_field("src_port_low", 32'(want.out_src_port_low),
					32'(result.out_src_port_low));
				compare_field("src_port_high", 32'(want.out_src_port_high),
					32'(result.out_src_port_high));
				compare_field("dst_port_low", 32'(want.out_dst_port_low),
					32'(result.out_dst_port_low));
				compare_field("dst_port_high", 32'(want.out_dst_port_high),
					32'(result.out_dst_port_high));
				compare_field("original_position", 32'(want.original_position),
					32'(result.original_position));
				compare_field("rules_dropped", 32'(want.rules_dropped),
					32'(result.rules_dropped));
				compare_field("end_of_run", 32'(want.end_of_run), 32'(result.end_of_run));
				results_checked++;
			end
		end
	end

	// stimulus: reset, directed table, random rule sets, drain
	initial begin : stimulus
		rrr_pkg::rule_item_t   full_rule;
		rrr_pkg::rule_item_t   narrow_rule;
		rrr_pkg::rule_item_t   inv_rule;
		rrr_pkg::rule_bounds_t b;
		logic [31:0]           lo[4];
		logic [31:0]           hi[4];
		int                    set_len;
		int                    set_idx;
		int                    random_sent;

		// single rule at the top of every range
		add_row(mk_rule(IP_MAX, IP_MAX, IP_MAX, IP_MAX, PORT_MAX, PORT_MAX, PORT_MAX, PORT_MAX,
			1'b1), 1'b1, mk_result(mk_rule(IP_MAX, IP_MAX, IP_MAX, IP_MAX, PORT_MAX, PORT_MAX,
			PORT_MAX, PORT_MAX, 1'b0), 0, 1'b0, 1'b1));
		// single rule at the bottom of every range
		add_row(mk_rule('0, '0, '0, '0, '0, '0, '0, '0, 1'b1), 1'b1,
			mk_result(mk_rule('0, '0, '0, '0, '0, '0, '0, '0, 1'b0), 0, 1'b0, 1'b1));

		// full cover first: duplicate, narrower and inverted rules all fall away
		full_rule   = mk_rule('0, IP_MAX, '0, IP_MAX, '0, PORT_MAX, '0, PORT_MAX, 1'b0);
		narrow_rule = mk_rule(10, 20, 30, 40, 50, 60, 70, 80, 1'b0);
		add_row(full_rule);
		add_row(full_rule);
		add_row(narrow_rule);
		add_row(mk_rule(IP_MAX, '0, IP_MAX, '0, PORT_MAX, '0, PORT_MAX, '0, 1'b0));
		add_row(mk_rule(10, 20, 30, 40, 50, 60, 70, 80, 1'b1), 1'b1,
			mk_result(full_rule, 0, 1'b0, 1'b1));

		// narrow first, then a wider variant, then wide; later duplicate and inverted covered
		narrow_rule = mk_rule(32'h0A00_0064, 32'h0A00_00C8, 32'hC0A8_0000, 32'hC0A8_FFFF,
			1024, 2048, 443, 443, 1'b0);
		add_row(narrow_rule);
		add_row(mk_rule(32'h0A00_0064, 32'h0A00_00C8, 32'hC0A8_0000, 32'hC0A8_FFFF,
			1024, 2048, 443, 444, 1'b0));
		add_row(full_rule);
		add_row(narrow_rule);
		add_row(mk_rule(32'h0A00_00C8, 32'h0A00_0064, 32'hC0A8_0000, 32'hC0A8_FFFF,
			1024, 2048, 443, 443, 1'b1));

		// inverted source range as first rule; its duplicate is still covered
		inv_rule = mk_rule(500, 100, '0, IP_MAX, '0, PORT_MAX, 80, 80, 1'b0);
		add_row(inv_rule);
		add_row(mk_rule(200, 300, '0, IP_MAX, '0, PORT_MAX, 80, 80, 1'b0));
		add_row(inv_rule);
		add_row(mk_rule(100, 100, 1, IP_MAX - 1, '0, PORT_MAX, 80, 80, 1'b1));

		// hold reset, then release it
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_rule(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

		// random sets; the third one runs past capacity with no rule covered
		set_idx     = 0;
		random_sent = 0;
		while (random_sent < RANDOM_RULES) begin
			if (set_idx == 2)
				set_len = CAPACITY + $urandom_range(4, 1);
			else if ($urandom_range(9, 0) == 0)
				set_len = $urandom_range(20, 9);
			else
				set_len = $urandom_range(8, 1);
			set_history.delete();
			for (int n = 0; n < set_len; n++) begin
				if (set_idx == 2) begin
					for (int k = 0; k < 4; k++)
						draw_range(k, lo[k], hi[k]);
					// both source bounds rise with arrival order, so no rule covers a later one
					lo[0] = {8'(n), 24'($urandom)};
					hi[0] = {8'(n + 128), 24'($urandom)};
					b = join_bounds(lo, hi);
				end else begin
					b = next_rule_bounds();
				end
				set_history.insert(set_history.size(), b);
				send_rule({b, n == set_len - 1}, 1'b0, '0);
				random_sent++;
			end
			if (set_len > CAPACITY)
				overflow_sets++;
			set_idx++;
		end

		@(negedge clk);
		rule_valid <= 1'b0;

		// wait for every survivor, then watch for strays
		while (pending_survivors.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d rules in %0d sets (%0d past capacity), table then random sets",
			rules_sent, sets_sent, overflow_sets);
		$display("run: %0d surviving rules checked under four idling patterns, %0d mismatches",
			results_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// hard stop
	initial begin
		#1_000_000;
		$display("timeout with %0d results outstanding", pending_survivors.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
